@@ hdl/pac_container_header_walker_macros.svh @@
// Assertion macros used by the header walker queue module.
`ifndef PAC_CONTAINER_HEADER_WALKER_MACROS_SVH
`define PAC_CONTAINER_HEADER_WALKER_MACROS_SVH
// Checks a condition in the same cycle as its trigger.
`define PCW_ASSERT_SAME(lbl, trig, cond, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) else $error(msg);
// Checks a condition in the cycle after its trigger.
`define PCW_ASSERT_NEXT(lbl, trig, cond, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);
`endif

@@ hdl/pcw_pkg.sv @@
// Types, constants and banner tables of the container header walker.
`timescale 1ns / 1ps
package pcw_pkg;
	localparam logic [3:0] ST_MEMBER    = 4'd0;
	localparam logic [3:0] ST_ACCEPT    = 4'd1;
	localparam logic [3:0] ST_SMALL     = 4'd2;
	localparam logic [3:0] ST_BANNER    = 4'd3;
	localparam logic [3:0] ST_TERM      = 4'd4;
	localparam logic [3:0] ST_SIG       = 4'd5;
	localparam logic [3:0] ST_FIRST     = 4'd6;
	localparam logic [3:0] ST_RANGE     = 4'd7;
	localparam logic [3:0] ST_NAME      = 4'd8;
	localparam logic [3:0] ST_PAD       = 4'd9;
	localparam logic [3:0] ST_NEXT      = 4'd10;
	localparam logic [3:0] ST_TRUNC     = 4'd11;

	localparam logic [31:0] MIN_FILE    = 32'h0000_00a0;
	localparam logic [32:0] MEMBER_SIZE = 33'd32;
	localparam logic [31:0] FIRST_MIN   = 32'h0000_0062;
	localparam logic [32:0] POS_MAX     = 33'h1_ffff_ffff;
	localparam logic [0:0]  REG_FILE_SIZE = 1'b0;

	typedef enum logic [3:0] {
		PH_HDR  = 4'b0001,
		PH_WAIT = 4'b0010,
		PH_MEMB = 4'b0100,
		PH_DONE = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [15:0] member_number;
		logic [31:0] header_offset;
		logic [32:0] payload_offset;
		logic [31:0] packed_size;
		logic [31:0] unpacked_size;
		logic [15:0] check_value;
		logic [7:0]  pack_method;
		logic [15:0] attribute_bits;
		logic [15:0] dos_date_word;
		logic [15:0] dos_time_word;
		logic [15:0] writer_version;
	} rec_t;

	function automatic logic [7:0] lead_char(input logic [2:0] idx);
		case (idx)
			3'd0: lead_char = 8'h50;
			3'd1: lead_char = 8'h41;
			3'd2: lead_char = 8'h43;
			3'd3: lead_char = 8'h20;
			3'd4: lead_char = 8'h2d;
			3'd5: lead_char = 8'h20;
			default: lead_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] vendor_char(input logic [3:0] idx);
		case (idx)
			4'd0:  vendor_char = 8'h42;
			4'd1:  vendor_char = 8'h56;
			4'd2:  vendor_char = 8'h52;
			4'd3:  vendor_char = 8'h50;
			4'd4:  vendor_char = 8'h20;
			4'd5:  vendor_char = 8'h53;
			4'd6:  vendor_char = 8'h6f;
			4'd7:  vendor_char = 8'h66;
			4'd8:  vendor_char = 8'h74;
			4'd9:  vendor_char = 8'h77;
			4'd10: vendor_char = 8'h61;
			4'd11: vendor_char = 8'h72;
			4'd12: vendor_char = 8'h65;
			default: vendor_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] term_char(input logic [1:0] idx);
		case (idx)
			2'd0: term_char = 8'h00;
			2'd1: term_char = 8'h0d;
			2'd2: term_char = 8'h0a;
			default: term_char = 8'h1a;
		endcase
	endfunction

	function automatic rec_t err_rec(input logic [3:0] code);
		rec_t r;
		r = '0;
		r.status = code;
		err_rec = r;
	endfunction
endpackage

@@ hdl/pcw_front.sv @@
// Byte parser that walks the archive and member headers and builds records.
`timescale 1ns / 1ps
module pcw_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [31:0]   file_size,
	input  logic          take,
	input  logic [7:0]    data_byte,
	input  logic          end_of_file,
	output pcw_pkg::rec_t rec_a,
	output pcw_pkg::rec_t rec_b,
	output logic [1:0]    push_n
);
	import pcw_pkg::*;

	phase_t      phase_q, phase_d;
	logic [32:0] pos_q, pos_d;
	logic [4:0]  rel_q, rel_d;
	logic [31:0] first_q, first_d;
	logic [15:0] decl_q, decl_d;
	logic [15:0] done_q, done_d;
	logic [31:0] start_q, start_d;
	logic [31:0] next_q, next_d;
	logic [31:0] unp_q, unp_d;
	logic [15:0] chk_q, chk_d;
	logic [7:0]  meth_q, meth_d;
	logic [15:0] attr_q, attr_d;
	logic [15:0] date_q, date_d;
	logic [15:0] time_q, time_d;
	logic [15:0] ver_q, ver_d;
	logic        nend_q, nend_d;
	logic        nseen_q, nseen_d;

	logic [6:0]  p;
	logic [4:0]  rel;
	logic [32:0] data_off;
	logic [15:0] decl_new;
	logic [15:0] done_inc;
	logic        bad_char;
	rec_t        mrec;

	assign p        = pos_q[6:0];
	assign data_off = {1'b0, start_d} + MEMBER_SIZE;
	assign done_inc = done_q + 16'd1;
	assign decl_new = {data_byte, decl_q[7:0]};
	assign bad_char = (data_byte < 8'h20) || (data_byte > 8'h7e) || (data_byte == 8'h2f) ||
		(data_byte == 8'h5c) || (data_byte == 8'h3a);

	always_comb begin
		mrec                = '0;
		mrec.status         = ST_MEMBER;
		mrec.member_number  = done_q;
		mrec.header_offset  = start_q;
		mrec.payload_offset = data_off;
		mrec.packed_size    = next_q - data_off[31:0];
		mrec.unpacked_size  = unp_q;
		mrec.check_value    = chk_q;
		mrec.pack_method    = meth_q;
		mrec.attribute_bits = attr_q;
		mrec.dos_date_word  = date_q;
		mrec.dos_time_word  = time_q;
		mrec.writer_version = ver_q;
	end

	always_comb begin
		phase_d = phase_q; rel_d = rel_q; first_d = first_q; decl_d = decl_q;
		done_d = done_q; start_d = start_q; next_d = next_q; unp_d = unp_q;
		chk_d = chk_q; meth_d = meth_q; attr_d = attr_q; date_d = date_q;
		time_d = time_q; ver_d = ver_q; nend_d = nend_q; nseen_d = nseen_q;
		rec_a = '0; rec_b = '0; push_n = 2'd0;
		rel = rel_q;
		pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + 33'd1;

		if (phase_q == PH_HDR) begin
			if (p == 7'd0 && file_size < MIN_FILE) begin
				rec_a = err_rec(ST_SMALL); push_n = 2'd1; phase_d = PH_DONE;
			end else if (p < 7'd6) begin
				if (data_byte != lead_char(p[2:0])) begin
					rec_a = err_rec(ST_BANNER); push_n = 2'd1; phase_d = PH_DONE;
				end
			end else if (p >= 7'd10 && p < 7'd23) begin
				if (data_byte != vendor_char(4'(p - 7'd10))) begin
					rec_a = err_rec(ST_BANNER); push_n = 2'd1; phase_d = PH_DONE;
				end
			end else if (p >= 7'h4c && p < 7'h50) begin
				if (data_byte != term_char(p[1:0])) begin
					rec_a = err_rec(ST_TERM); push_n = 2'd1; phase_d = PH_DONE;
				end
			end else if (p == 7'h50 || p == 7'h51) begin
				if (data_byte != (p[0] ? 8'ha9 : 8'hd6)) begin
					rec_a = err_rec(ST_SIG); push_n = 2'd1; phase_d = PH_DONE;
				end
			end else if (p == 7'h52) begin
				ver_d[7:0] = data_byte;
			end else if (p == 7'h53) begin
				ver_d[15:8] = data_byte;
			end else if (p >= 7'h5c && p < 7'h60) begin
				case (p[1:0])
					2'd0: first_d[7:0]   = data_byte;
					2'd1: first_d[15:8]  = data_byte;
					2'd2: first_d[23:16] = data_byte;
					default: first_d[31:24] = data_byte;
				endcase
			end else if (p == 7'h60) begin
				decl_d = {8'h00, data_byte};
			end else if (p == 7'h61) begin
				decl_d = decl_new;
				if (first_q < FIRST_MIN ||
					{1'b0, first_q} + MEMBER_SIZE > {1'b0, file_size} ||
					decl_new == 16'd0) begin
					rec_a = err_rec(ST_FIRST); push_n = 2'd1; phase_d = PH_DONE;
				end else begin
					next_d = first_q; phase_d = PH_WAIT;
				end
			end
		end else if (phase_q == PH_WAIT && pos_q == {1'b0, next_q}) begin
			start_d = next_q; next_d = '0; unp_d = '0; chk_d = '0; meth_d = '0;
			attr_d = '0; date_d = '0; time_d = '0; nend_d = 1'b0; nseen_d = 1'b0;
			rel = 5'd0;
			phase_d = PH_MEMB;
		end

		if (phase_d == PH_MEMB) begin
			rel_d = rel + 5'd1;
			if (rel < 5'd12) begin
				if (!nend_d) begin
					if (data_byte == 8'h00) begin
						if (!nseen_d) begin
							rec_a = err_rec(ST_NAME); push_n = 2'd1; phase_d = PH_DONE;
						end else begin
							nend_d = 1'b1;
						end
					end else if (bad_char) begin
						rec_a = err_rec(ST_NAME); push_n = 2'd1; phase_d = PH_DONE;
					end else begin
						nseen_d = 1'b1;
					end
				end
			end else begin
				case (rel)
					5'd12: attr_d[7:0]    = data_byte;
					5'd13: attr_d[15:8]   = data_byte;
					5'd14: date_d[7:0]    = data_byte;
					5'd15: date_d[15:8]   = data_byte;
					5'd16: time_d[7:0]    = data_byte;
					5'd17: time_d[15:8]   = data_byte;
					5'd18: meth_d         = data_byte;
					5'd19: next_d[7:0]    = data_byte;
					5'd20: next_d[15:8]   = data_byte;
					5'd21: next_d[23:16]  = data_byte;
					5'd22: next_d[31:24]  = data_byte;
					5'd23: unp_d[7:0]     = data_byte;
					5'd24: unp_d[15:8]    = data_byte;
					5'd25: unp_d[23:16]   = data_byte;
					5'd26: unp_d[31:24]   = data_byte;
					5'd27: chk_d[7:0]     = data_byte;
					5'd28: chk_d[15:8]    = data_byte;
					5'd31: begin
						if (data_byte != 8'h00) begin
							rec_a = err_rec(ST_PAD); push_n = 2'd1; phase_d = PH_DONE;
						end else if ({1'b0, next_q} < data_off || next_q > file_size) begin
							rec_a = err_rec(ST_NEXT); push_n = 2'd1; phase_d = PH_DONE;
						end else begin
							rec_a = mrec; push_n = 2'd1;
							done_d = done_inc;
							if (done_inc == decl_q) begin
								rec_b = '0;
								rec_b.status = ST_ACCEPT;
								rec_b.member_number = decl_q;
								rec_b.header_offset = next_q;
								push_n = 2'd2; phase_d = PH_DONE;
							end else if ({1'b0, next_q} + MEMBER_SIZE > {1'b0, file_size}) begin
								rec_b = err_rec(ST_RANGE); push_n = 2'd2; phase_d = PH_DONE;
							end else begin
								phase_d = PH_WAIT;
							end
						end
					end
					default: ;
				endcase
			end
		end

		if (end_of_file && phase_d != PH_DONE) begin
			if (push_n == 2'd0) begin
				rec_a = err_rec(ST_TRUNC); push_n = 2'd1;
			end else begin
				rec_b = err_rec(ST_TRUNC); push_n = 2'd2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR; pos_q <= '0; rel_q <= '0; first_q <= '0; decl_q <= '0;
			done_q <= '0; start_q <= '0; next_q <= '0; unp_q <= '0; chk_q <= '0;
			meth_q <= '0; attr_q <= '0; date_q <= '0; time_q <= '0; ver_q <= '0;
			nend_q <= 1'b0; nseen_q <= 1'b0;
		end else if (take) begin
			if (end_of_file) begin
				phase_q <= PH_HDR; pos_q <= '0; rel_q <= '0; first_q <= '0; decl_q <= '0;
				done_q <= '0; start_q <= '0; next_q <= '0; unp_q <= '0; chk_q <= '0;
				meth_q <= '0; attr_q <= '0; date_q <= '0; time_q <= '0; ver_q <= '0;
				nend_q <= 1'b0; nseen_q <= 1'b0;
			end else begin
				phase_q <= phase_d; pos_q <= pos_d; rel_q <= rel_d; first_q <= first_d;
				decl_q <= decl_d; done_q <= done_d; start_q <= start_d; next_q <= next_d;
				unp_q <= unp_d; chk_q <= chk_d; meth_q <= meth_d; attr_q <= attr_d;
				date_q <= date_d; time_q <= time_d; ver_q <= ver_d;
				nend_q <= nend_d; nseen_q <= nseen_d;
			end
		end
	end
endmodule

@@ hdl/pcw_queue.sv @@
// Record queue with two write slots and one read slot per cycle.
`timescale 1ns / 1ps
`include "pac_container_header_walker_macros.svh"
module pcw_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    push_n,
	input  pcw_pkg::rec_t rec_a,
	input  pcw_pkg::rec_t rec_b,
	input  logic          pop,
	output pcw_pkg::rec_t head,
	output logic          not_empty,
	output logic          full_for_two
);
	import pcw_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	rec_t          slot_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q, wptr_1;
	logic [CW-1:0] cnt_q;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
		ptr_inc = (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
	endfunction

	assign wptr_1       = ptr_inc(wptr_q);
	assign head         = slot_q[rptr_q];
	assign not_empty    = cnt_q != '0;
	assign full_for_two = cnt_q > CW'(DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			slot_q[wptr_q] <= rec_a;
		end
		if (push_n == 2'd2) begin
			slot_q[wptr_1] <= rec_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push_n == 2'd1) begin
				wptr_q <= wptr_1;
			end else if (push_n == 2'd2) begin
				wptr_q <= ptr_inc(wptr_1);
			end
			if (pop) begin
				rptr_q <= ptr_inc(rptr_q);
			end
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

	`PCW_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH), "queue count beyond depth")
	`PCW_ASSERT_SAME(a_pair_room, push_n == 2'd2, cnt_q - CW'(pop) <= CW'(DEPTH - 2), "no room for pair")
	`PCW_ASSERT_NEXT(a_pop_only, pop && push_n == 2'd0, cnt_q == $past(cnt_q) - CW'(1), "pop count slip")
endmodule

@@ hdl/pcw_back.sv @@
// Output register that drains the record queue towards the result channel.
`timescale 1ns / 1ps
module pcw_back (
	input  logic          clk,
	input  logic          arst_n,
	input  pcw_pkg::rec_t head,
	input  logic          not_empty,
	input  logic          out_stall,
	output logic          pop,
	output logic          out_valid,
	output pcw_pkg::rec_t out_rec
);
	import pcw_pkg::*;

	logic valid_q;
	rec_t rec_q;

	assign pop       = not_empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_rec   = rec_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= not_empty;
		end
	end
endmodule

@@ hdl/pac_container_header_walker.sv @@
// Top level of the archive container header walker.
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    data_byte, end_of_file
//  result    out        out_valid / out_stall  status .. writer_version
//  config    in         APB psel / penable     file_size at address 0
// One byte is taken per cycle while in_stall is low; the parser decides each
// byte in that cycle. A byte may produce two records; the record queue holds
// the input for as long as it has fewer than two free slots.
// Results reach the output through the queue and then the output register.
// Reset clears all parse state and file_size.
`timescale 1ns / 1ps
module pac_container_header_walker #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [15:0] member_number,
	output logic [31:0] header_offset,
	output logic [32:0] payload_offset,
	output logic [31:0] packed_size,
	output logic [31:0] unpacked_size,
	output logic [15:0] check_value,
	output logic [7:0]  pack_method,
	output logic [15:0] attribute_bits,
	output logic [15:0] dos_date_word,
	output logic [15:0] dos_time_word,
	output logic [15:0] writer_version,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pcw_pkg::*;

	logic [31:0] file_size_q;
	logic        take, pop, not_empty, full_for_two;
	logic [1:0]  push_n;
	rec_t        rec_a, rec_b, head, out_rec;

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_FILE_SIZE) ? file_size_q : 32'd0;
	assign in_stall = full_for_two;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_FILE_SIZE) begin
			file_size_q <= pwdata;
		end
	end

	pcw_front u_front (
		.clk(clk), .arst_n(arst_n), .file_size(file_size_q), .take(take),
		.data_byte(data_byte), .end_of_file(end_of_file),
		.rec_a(rec_a), .rec_b(rec_b), .push_n(push_n)
	);

	pcw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push_n(take ? push_n : 2'd0),
		.rec_a(rec_a), .rec_b(rec_b), .pop(pop), .head(head),
		.not_empty(not_empty), .full_for_two(full_for_two)
	);

	pcw_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .not_empty(not_empty),
		.out_stall(out_stall), .pop(pop), .out_valid(out_valid), .out_rec(out_rec)
	);

	assign status         = out_rec.status;
	assign member_number  = out_rec.member_number;
	assign header_offset  = out_rec.header_offset;
	assign payload_offset = out_rec.payload_offset;
	assign packed_size    = out_rec.packed_size;
	assign unpacked_size  = out_rec.unpacked_size;
	assign check_value    = out_rec.check_value;
	assign pack_method    = out_rec.pack_method;
	assign attribute_bits = out_rec.attribute_bits;
	assign dos_date_word  = out_rec.dos_date_word;
	assign dos_time_word  = out_rec.dos_time_word;
	assign writer_version = out_rec.writer_version;
endmodule
